/* rtl/tcpt_pkg.sv */
// Shared types, codes and helpers for the three-channel programmable timer.
package tcpt_pkg;

    localparam int NumTimers = 3;
    localparam int CountW    = 17;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // Control register bits
    localparam int CtlSel1  = 0;
    localparam int CtlEclk  = 1;
    localparam int CtlDual  = 2;
    localparam int CtlIrqEn = 6;

    // Register offsets with a fixed meaning
    localparam logic [2:0] OffCtl13 = 3'd0;
    localparam logic [2:0] OffCtl2  = 3'd1;

    // Request on the input stream, last field in the low bits
    typedef struct packed {
        logic [7:0] write_data;
        logic [2:0] bus_offset;
        cmd_t       command;
    } item_t;

    // Result on the output stream
    typedef struct packed {
        logic       irq_pending;
        logic [7:0] read_data;
    } result_t;

    // One-shot load value: msb*256+lsb+1, or (lsb+1)*(msb+1) in dual 8-bit mode
    function automatic logic [CountW-1:0] load_count(
        input logic [7:0] ctl,
        input logic [7:0] lsb,
        input logic [7:0] msb
    );
        logic [8:0]        lsb_p1;
        logic [8:0]        msb_p1;
        logic [CountW-1:0] prod;
        logic [CountW-1:0] lin;
        lsb_p1 = {1'b0, lsb} + 9'd1;
        msb_p1 = {1'b0, msb} + 9'd1;
        prod   = CountW'(lsb_p1) * CountW'(msb_p1);
        lin    = {1'b0, msb, lsb} + CountW'(1);
        return ctl[CtlDual] ? prod : lin;
    endfunction

endpackage

/* rtl/three_channel_programmable_timer_unit.sv */
// Three-channel programmable timer: register file, timer counters and stream ports.
//
// Each request on the slave stream is a bus read, a bus write or one E-clock
// tick; each produces exactly one result (read data and interrupt-pending flag)
// on the master stream. Requests are taken at one per cycle unless stalled: a
// request is held in an input register, the register-file and counter update
// is a combinational step from that register, and the result lands in an
// output register that drives m_tvalid. The input side keeps accepting while
// a finished result waits, and stalls only when both the input and output
// registers are full and m_tready is low. Writing offset 0 or 1 stores a control
// register and reloads/arms its timer (offset 0 reaches timer 1 when control
// register 2 bit 0 is set, else timer 3). Offsets 2/4/6 write the shared MSB
// buffer, 3/5/7 write a timer's LSB latch and copy the MSB buffer into its MSB
// latch; any access at a counter offset clears that timer's status flag. A read
// of offset 1 refreshes the composite bit 7 and returns the status byte; other
// reads return zero (counter readback is not provided). External clock, gates
// and timer outputs are not implemented.
module three_channel_programmable_timer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] command, [4:2] bus_offset, [12:5] write_data, [15:13] zero
    input  logic [15:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] read_data, [8] irq_pending, [15:9] zero
    output logic [15:0] m_tdata
);
    import tcpt_pkg::*;

    // Stream staging
    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    logic    advance;     // output register free to take a result
    logic    do_step;     // request in the input register is executed now

    // Register file and timers
    logic [7:0]        ctl_reg  [NumTimers];
    logic [7:0]        ctl_next [NumTimers];
    logic [7:0]        lsb_reg  [NumTimers];
    logic [7:0]        lsb_next [NumTimers];
    logic [7:0]        msb_reg  [NumTimers];
    logic [7:0]        msb_next [NumTimers];
    logic [CountW-1:0] rem_reg  [NumTimers];
    logic [CountW-1:0] rem_next [NumTimers];
    logic [NumTimers-1:0] armed_reg, armed_next;
    logic [NumTimers-1:0] flags_reg, flags_next;
    logic                 comp_reg, comp_next;
    logic [7:0]           msb_buf_reg, msb_buf_next;

    result_t res_next;

    assign advance  = !out_valid_reg || m_tready;
    assign do_step  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_res_reg};

    // Execute one request against the register file
    always_comb begin
        logic [2:0]           off;
        logic [7:0]           data;
        logic [NumTimers-1:0] owner;
        logic [NumTimers-1:0] wr_ctl;
        logic [CountW-1:0]    dec;
        off  = in_item_reg.bus_offset;
        data = in_item_reg.write_data;

        for (int i = 0; i < NumTimers; i++) begin
            ctl_next[i] = ctl_reg[i];
            lsb_next[i] = lsb_reg[i];
            msb_next[i] = msb_reg[i];
            rem_next[i] = rem_reg[i];
        end
        armed_next   = armed_reg;
        flags_next   = flags_reg;
        comp_next    = comp_reg;
        msb_buf_next = msb_buf_reg;
        res_next     = '0;
        dec          = '0;

        // timer owning a counter offset: 2,3 -> 0; 4,5 -> 1; 6,7 -> 2
        for (int i = 0; i < NumTimers; i++) begin
            owner[i] = (off[2:1] == 2'(i + 1));
        end

        // control register targeted by offset 0/1
        wr_ctl    = '0;
        wr_ctl[1] = (off == OffCtl2);
        wr_ctl[0] = (off == OffCtl13) && ctl_reg[1][CtlSel1];
        wr_ctl[2] = (off == OffCtl13) && !ctl_reg[1][CtlSel1];

        unique case (in_item_reg.command)
            CMD_READ: begin
                if (off == OffCtl2) begin
                    comp_next          = |flags_reg;
                    res_next.read_data = {|flags_reg, 4'd0, flags_reg};
                end else begin
                    flags_next = flags_reg & ~owner;
                end
            end
            CMD_WRITE: begin
                if (off[2:1] == 2'd0) begin
                    for (int i = 0; i < NumTimers; i++) begin
                        if (wr_ctl[i]) begin
                            ctl_next[i]   = data;
                            rem_next[i]   = load_count(data, lsb_reg[i], msb_reg[i]);
                            armed_next[i] = 1'b1;
                        end
                    end
                end else begin
                    flags_next = flags_reg & ~owner;
                    if (off[0]) begin
                        for (int i = 0; i < NumTimers; i++) begin
                            if (owner[i]) begin
                                lsb_next[i] = data;
                                msb_next[i] = msb_buf_reg;
                            end
                        end
                    end else begin
                        msb_buf_next = data;
                    end
                end
            end
            CMD_TICK: begin
                for (int i = 0; i < NumTimers; i++) begin
                    if (armed_reg[i] && ctl_reg[i][CtlEclk]) begin
                        dec         = (rem_reg[i] == '0) ? '0 : rem_reg[i] - CountW'(1);
                        rem_next[i] = dec;
                        if (dec == '0) begin
                            armed_next[i] = 1'b0;
                            if (ctl_reg[i][CtlIrqEn]) begin
                                flags_next[i] = 1'b1;
                            end
                        end
                    end
                end
            end
            default: begin
                // undefined command: no effect
            end
        endcase

        res_next.irq_pending = |flags_next;
    end

    // Stream control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (do_step) begin
                in_valid_reg <= 1'b0;
            end
            if (do_step) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Stream payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= item_t'(s_tdata[12:0]);
        end
        if (do_step) begin
            out_res_reg <= res_next;
        end
    end

    // Register file and timer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NumTimers; i++) begin
                ctl_reg[i] <= '0;
                lsb_reg[i] <= 8'hff;
                msb_reg[i] <= 8'hff;
                rem_reg[i] <= '0;
            end
            armed_reg   <= '0;
            flags_reg   <= '0;
            comp_reg    <= 1'b0;
            msb_buf_reg <= '0;
        end else if (do_step) begin
            for (int i = 0; i < NumTimers; i++) begin
                ctl_reg[i] <= ctl_next[i];
                lsb_reg[i] <= lsb_next[i];
                msb_reg[i] <= msb_next[i];
                rem_reg[i] <= rem_next[i];
            end
            armed_reg   <= armed_next;
            flags_reg   <= flags_next;
            comp_reg    <= comp_next;
            msb_buf_reg <= msb_buf_next;
        end
    end

    // A freshly produced result reports the flags as they stand after the request
    assert property (@(posedge aclk) disable iff (!aresetn)
        do_step |=> (out_res_reg.irq_pending == (|flags_reg)))
        else $error("irq_pending disagrees with status flags");

    // Composite bit moves only on a status read
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(do_step && in_item_reg.command == CMD_READ && in_item_reg.bus_offset == OffCtl2)
        |=> $stable(comp_reg))
        else $error("composite bit changed outside a status read");

    // An armed timer always holds a nonzero count
    assert property (@(posedge aclk) disable iff (!aresetn)
        !((armed_reg[0] && rem_reg[0] == '0) || (armed_reg[1] && rem_reg[1] == '0)
          || (armed_reg[2] && rem_reg[2] == '0)))
        else $error("armed timer with zero count");

    // Input register is never overwritten while its request is still pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("pending request lost");

endmodule

/* verif/tcpt_checker.sv */
// Request/result checker for the three-channel timer: predicts every result and compares it.
module tcpt_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    output int          fail_count,
    output int          pending,
    output int          requests_seen,
    output int          status_reads,
    output int          flags_raised,
    output int          irq_results
);
    timeunit 1ns;
    timeprecision 1ps;
    import tcpt_pkg::*;

    // predicted timer state
    logic [7:0]        ctl_r [NumTimers];
    logic [7:0]        lsb_r [NumTimers];
    logic [7:0]        msb_r [NumTimers];
    logic [CountW-1:0] ticks_left [NumTimers];
    logic              armed [NumTimers];
    logic [7:0]        msb_buf;
    logic [7:0]        status;

    result_t expected_results [$];

    task automatic apply_request(input item_t req, output result_t res);
        int idx;
        logic [CountW-1:0] lsb_w;
        logic [CountW-1:0] msb_w;
        res = '0;
        case (req.command)
            CMD_READ: begin
                if (req.bus_offset == OffCtl2) begin
                    status[7] = |status[2:0];
                    res.read_data = status;
                    status_reads++;
                end else if (req.bus_offset > OffCtl2) begin
                    status[int'(req.bus_offset >> 1) - 1] = 1'b0;
                end
            end
            CMD_WRITE: begin
                if (req.bus_offset <= OffCtl2) begin
                    if (req.bus_offset == OffCtl2)
                        idx = 1;
                    else
                        idx = ctl_r[1][CtlSel1] ? 0 : 2;
                    ctl_r[idx] = req.write_data;
                    lsb_w = CountW'(lsb_r[idx]);
                    msb_w = CountW'(msb_r[idx]);
                    if (req.write_data[CtlDual])
                        ticks_left[idx] = CountW'((lsb_w + 1) * (msb_w + 1));
                    else
                        ticks_left[idx] = CountW'(msb_w * 256 + lsb_w + 1);
                    armed[idx] = 1'b1;
                end else begin
                    idx = int'(req.bus_offset >> 1) - 1;
                    status[idx] = 1'b0;
                    if (req.bus_offset[0]) begin
                        lsb_r[idx] = req.write_data;
                        msb_r[idx] = msb_buf;
                    end else begin
                        msb_buf = req.write_data;
                    end
                end
            end
            CMD_TICK: begin
                for (int t = 0; t < NumTimers; t++) begin
                    if (armed[t] && ctl_r[t][CtlEclk]) begin
                        if (ticks_left[t] != 0)
                            ticks_left[t]--;
                        if (ticks_left[t] == 0) begin
                            armed[t] = 1'b0;
                            if (ctl_r[t][CtlIrqEn]) begin
                                status[t] = 1'b1;
                                flags_raised++;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        res.irq_pending = |status[2:0];
    endtask

    initial begin
        fail_count    = 0;
        pending       = 0;
        requests_seen = 0;
        status_reads  = 0;
        flags_raised  = 0;
        irq_results   = 0;
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        result_t fresh;
        if (!aresetn) begin
            for (int t = 0; t < NumTimers; t++) begin
                ctl_r[t]      = 8'h00;
                lsb_r[t]      = 8'hff;
                msb_r[t]      = 8'hff;
                ticks_left[t] = '0;
                armed[t]      = 1'b0;
            end
            msb_buf = 8'h00;
            status  = 8'h00;
            expected_results.delete();
        end else begin
            // retire first: a result always belongs to an older request
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[8:0]);
                if (got.irq_pending)
                    irq_results++;
                if (expected_results.size() == 0) begin
                    $error("result %0h with no request outstanding", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.read_data !== want.read_data) begin
                        $error("read_data: expected %0h, got %0h", want.read_data,
                               got.read_data);
                        fail_count++;
                    end
                    if (got.irq_pending !== want.irq_pending) begin
                        $error("irq_pending: expected %0b, got %0b", want.irq_pending,
                               got.irq_pending);
                        fail_count++;
                    end
                    if (m_tdata[15:9] !== 7'd0) begin
                        $error("padding: expected 0, got %0h", m_tdata[15:9]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                apply_request(item_t'(s_tdata[12:0]), fresh);
                expected_results.push_back(fresh);
                requests_seen++;
            end
        end
        pending = expected_results.size();
    end

endmodule

/* verif/tb_three_channel_programmable_timer_unit.sv */
// Testbench top for the three-channel timer: clock, reset, request stimulus and verdict.
module tb_three_channel_programmable_timer_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import tcpt_pkg::*;

    localparam int ItemsTarget = 1550;
    localparam int QuietTail   = 100;  // last requests sent with no idling
    localparam int HoldCycles  = 400;  // long receiver hold-off
    localparam int HoldAt      = 700;  // request count that triggers the hold-off

    // counter offsets: MSB buffer on the even ones, a timer's LSB latch on the odd ones
    localparam logic [2:0] OffMsb1 = 3'd2;
    localparam logic [2:0] OffLsb1 = 3'd3;
    localparam logic [2:0] OffMsb2 = 3'd4;
    localparam logic [2:0] OffLsb2 = 3'd5;
    localparam logic [2:0] OffMsb3 = 3'd6;
    localparam logic [2:0] OffLsb3 = 3'd7;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    int fail_count;
    int pending;
    int requests_seen;
    int status_reads;
    int flags_raised;
    int irq_results;

    // shared between the request and result processes
    bit quiet        = 1'b0;  // no idling on either side
    bit hold_off_req = 1'b0;  // sender asks the receiver for one long stall
    int sent         = 0;

    // sender idling runs in stretches: some gappy, some back to back
    int s_stretch_left = 0;
    bit s_gappy        = 1'b0;

    three_channel_programmable_timer_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    tcpt_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .requests_seen (requests_seen),
        .status_reads  (status_reads),
        .flags_raised  (flags_raised),
        .irq_results   (irq_results)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Offer one request and hold it until taken. s_tready is sampled at the
    // falling edge, where everything driven at the rising edge has settled,
    // so the handshake lands on the rising edge that follows.
    task automatic put(input cmd_t cmd, input logic [2:0] off, input logic [7:0] data);
        item_t req;
        bit    took;
        req.command    = cmd;
        req.bus_offset = off;
        req.write_data = data;
        if (s_stretch_left == 0) begin
            s_gappy        = $urandom_range(0, 1);
            s_stretch_left = $urandom_range(8, 50);
        end
        s_stretch_left--;
        if (!quiet && s_gappy && $urandom_range(0, 2) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, req};
        took = 1'b0;
        while (!took) begin
            @(negedge aclk);
            took = s_tready;
            @(posedge aclk);
        end
        sent++;
    endtask

    // Result side: random ready/stall bursts, one long hold-off on request,
    // always ready in the quiet tail.
    initial begin
        int held;
        wait (aresetn);
        forever begin
            if (hold_off_req) begin
                m_tready <= 1'b0;
                held = 0;
                while (held < HoldCycles) begin
                    @(posedge aclk);
                    held++;
                end
                hold_off_req = 1'b0;
            end else if (quiet || $urandom_range(0, 1) == 0) begin
                m_tready <= 1'b1;
                repeat (quiet ? 1 : $urandom_range(1, 40)) @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end
        end
    end

    // Watchdog, far above the slowest legal run
    initial begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        int         t;
        int         n;
        bit         hold_done;
        logic [7:0] msb_v;
        logic [7:0] lsb_v;
        logic [7:0] ctl_v;
        logic [7:0] sel_v;
        hold_done = 1'b0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // ---- directed requests ----
        put(CMD_READ,  OffCtl2,  8'h00);   // status right after reset
        put(CMD_NONE,  OffLsb3,  8'hff);   // unknown command does nothing
        put(CMD_READ,  OffCtl13, 8'hff);   // reads outside status return zero
        put(CMD_READ,  OffMsb2,  8'h00);
        // timer 1: count of one, expires on the first tick
        put(CMD_WRITE, OffMsb1,  8'h00);
        put(CMD_WRITE, OffLsb1,  8'h00);
        put(CMD_WRITE, OffCtl2,  8'hc3);   // select timer 1 on offset 0; timer 2 at full count
        put(CMD_WRITE, OffCtl13, 8'h42);   // E-clock, interrupt enable
        put(CMD_TICK,  OffCtl13, 8'h00);
        put(CMD_READ,  OffCtl2,  8'h00);   // composite bit should now be set
        put(CMD_READ,  OffLsb1,  8'h00);   // counter read clears timer 1 flag
        put(CMD_READ,  OffCtl2,  8'h00);   // composite bit drops again
        // timer 3 with largest latches in dual 8-bit mode
        put(CMD_WRITE, OffMsb3,  8'hff);
        put(CMD_WRITE, OffLsb3,  8'hff);
        put(CMD_WRITE, OffCtl2,  8'h02);   // offset 0 now reaches timer 3
        put(CMD_WRITE, OffCtl13, 8'h46);
        // timer 2 on the external clock: armed but frozen
        put(CMD_WRITE, OffMsb2,  8'h00);
        put(CMD_WRITE, OffLsb2,  8'h01);
        put(CMD_WRITE, OffCtl2,  8'h44);
        put(CMD_TICK,  OffMsb3,  8'hff);
        put(CMD_TICK,  OffLsb2,  8'h5a);
        // rewrite while counting reloads: dual mode count of two
        put(CMD_WRITE, OffCtl2,  8'h46);
        put(CMD_TICK,  OffCtl2,  8'ha5);
        put(CMD_TICK,  OffCtl2,  8'h00);
        put(CMD_READ,  OffCtl2,  8'h00);
        put(CMD_WRITE, OffMsb2,  8'haa);   // counter write clears timer 2 flag
        put(CMD_READ,  OffCtl2,  8'h00);

        // ---- random requests ----
        while (sent < ItemsTarget) begin
            n = $urandom_range(0, 99);
            if (n < 50) begin
                // program one timer: MSB buffer, LSB latch, then its control register
                t     = $urandom_range(0, NumTimers - 1);
                msb_v = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
                lsb_v = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20));
                ctl_v = 8'($urandom);
                if ($urandom_range(0, 4) != 0)
                    ctl_v[CtlEclk] = 1'b1;
                if ($urandom_range(0, 4) != 0)
                    ctl_v[CtlIrqEn] = 1'b1;
                put(CMD_WRITE, OffMsb1 + 3'(2 * t), msb_v);
                put(CMD_WRITE, OffLsb1 + 3'(2 * t), lsb_v);
                if (t == 1) begin
                    put(CMD_WRITE, OffCtl2, ctl_v);
                end else begin
                    sel_v          = 8'($urandom);
                    sel_v[CtlSel1] = (t == 0);
                    put(CMD_WRITE, OffCtl2, sel_v);
                    put(CMD_WRITE, OffCtl13, ctl_v);
                end
            end else if (n < 78) begin
                // tick burst, then look at status
                repeat ($urandom_range(1, 60))
                    put(CMD_TICK, 3'($urandom_range(0, 7)), 8'($urandom));
                put(CMD_READ, OffCtl2, 8'($urandom));
            end else if (n < 90) begin
                // interrupt service: read status, touch a counter offset
                put(CMD_READ, OffCtl2, 8'($urandom));
                put($urandom_range(0, 1) ? CMD_READ : CMD_WRITE,
                    3'($urandom_range(OffMsb1, OffLsb3)), 8'($urandom));
            end else begin
                // noise, unknown command included
                put(cmd_t'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), 8'($urandom));
            end

            if (!hold_done && sent >= HoldAt) begin
                hold_off_req = 1'b1;
                hold_done    = 1'b1;
            end
            if (sent >= ItemsTarget - QuietTail)
                quiet = 1'b1;
        end
        s_tvalid <= 1'b0;

        // drain, then wait for anything stray from the pipeline
        do @(negedge aclk); while (pending != 0);
        repeat (8) @(posedge aclk);

        $display("Covered %0d requests with %0d status reads and %0d flagged expirations;",
                 requests_seen, status_reads, flags_raised);
        $display("%0d results came back with an interrupt pending.", irq_results);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
